/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the windowed metrics block.
// No dependencies; builds with SYNTH defined reduce every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/wcm_pkg.sv */
// Types and constants of the windowed classification metrics block.
// No dependencies; the top level, front end, queue and back end import it.
package wcm_pkg;

    localparam int CFG_WIDTH   = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 32;
    localparam int RATIO_STEPS = 16;

    localparam logic [CFG_WIDTH-1:0] WLEN_RESET = 7'd16;

    localparam logic [1:0] LABEL_NONE   = 2'd0;
    localparam logic [1:0] LABEL_FIRST  = 2'd1;
    localparam logic [1:0] LABEL_SECOND = 2'd2;

    localparam logic [31:0] METRIC_SAT = 32'hFFFF_FFFF;
    localparam logic [31:0] RATIO_SAT  = 32'h0001_0000;

    typedef struct packed {
        logic signed [31:0] first_sum;
        logic signed [31:0] second_sum;
        logic [1:0]         expected_label;
        logic signed [31:0] effort_value;
        logic signed [31:0] energy_value;
    } in_item_t;

    typedef struct packed {
        logic        item_correct;
        logic [31:0] effort_metric;
        logic [31:0] energy_metric;
        logic [16:0] correct_ratio;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_REMOVE,
        F_APPEND
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SETUP,
        B_ITER,
        B_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        OP_EFFORT,
        OP_ENERGY,
        OP_RATIO
    } div_op_t;

endpackage

/* hdl/windowed_classification_metrics.sv */
// Top level of the windowed classification metrics block.
// Depends on wcm_pkg, wcm_front, wcm_fifo, wcm_back and assert_macros.svh.
//
//   Channel   Ports                       Carries
//   input     s_valid s_ready s_data      in_item_t: sums, label, effort, energy
//   config    cfg_valid cfg_ready cfg_data window_length, 7 bits
//   result    m_valid m_ready m_data      out_item_t: flag, two metrics, ratio
//
// The front end takes each item through accept, ring read, oldest removal and
// append, and holds in append while the queue is full; the back end skips any of
// its three divisions whose quotient is zero or saturated. The shared radix-2
// divider, one quotient bit a cycle, sets the sustained rate while it runs.
// Reset empties the window and sets window_length to 16; the ring needs no clearing.
// A two-entry queue and the output register let either side stall independently.
`include "assert_macros.svh"

module windowed_classification_metrics
    import wcm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int TW = VALUE_WIDTH + $clog2(WINDOW_MAX);
    localparam int QW = 1 + 2 * CW + 2 * TW;

    logic          q_push, q_pop;
    logic [QW-1:0] q_wdata, q_rdata;
    fifo_status_t  q_stat;

    wcm_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_stat    (q_stat)
    );

    wcm_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    wcm_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_pop   (q_pop),
        .q_data  (q_rdata),
        .q_stat  (q_stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `ASSERT_IMPLIES(a_push_has_room, aclk, aresetn, q_push, !q_stat.full)
    `ASSERT_IMPLIES(a_pop_has_data, aclk, aresetn, q_pop, !q_stat.empty)
    `ASSERT_IMPLIES(a_push_while_busy, aclk, aresetn, q_push, !s_ready)
    `ASSERT_NEXT(a_queue_empty_after_reset, aclk, 1'b1, !aresetn, q_stat.empty)

endmodule

/* hdl/wcm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/wcm_front.sv */
// Front end: accepts items, classifies them and keeps the sliding window.
// Depends on wcm_pkg and wcm_ram; pushes window totals into the queue.
module wcm_front
    import wcm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int CW = $clog2(WINDOW_MAX + 1),
    localparam int TW = VALUE_WIDTH + $clog2(WINDOW_MAX),
    localparam int QW = 1 + 2 * CW + 2 * TW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output logic                 q_push,
    output logic [QW-1:0]        q_data,
    input  fifo_status_t         q_stat
);

    localparam int RW = 1 + 2 * VALUE_WIDTH;

    front_state_t          state_reg, state_next;
    in_item_t              item_reg;
    logic                  ok_reg, ok_next;
    logic [CFG_WIDTH-1:0]  wlen_reg, wlen_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         count_reg, count_next;
    logic signed [TW-1:0]  eff_tot_reg, eff_tot_next;
    logic signed [TW-1:0]  ene_tot_reg, ene_tot_next;

    logic signed [VALUE_WIDTH-1:0] s1_v, s2_v, eff_v, ene_v;
    logic signed [VALUE_WIDTH-1:0] rd_eff, rd_ene;
    logic                  rd_flag;
    logic [1:0]            pred;
    logic [CW-1:0]         len_eff;
    logic                  window_full;
    logic [AW-1:0]         old_idx;
    logic                  append_fire;
    logic [CW-1:0]         count_sum;
    logic signed [TW-1:0]  eff_sum, ene_sum;
    logic                  ram_we, ram_re;
    logic [RW-1:0]         ram_wdata, ram_rdata;

    assign s1_v  = VALUE_WIDTH'({32'b0, item_reg.first_sum});
    assign s2_v  = VALUE_WIDTH'({32'b0, item_reg.second_sum});
    assign eff_v = VALUE_WIDTH'({32'b0, item_reg.effort_value});
    assign ene_v = VALUE_WIDTH'({32'b0, item_reg.energy_value});

    assign rd_flag = ram_rdata[RW-1];
    assign rd_eff  = ram_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    assign rd_ene  = ram_rdata[VALUE_WIDTH-1:0];

    always_comb begin
        if (s1_v > s2_v) begin
            pred = LABEL_FIRST;
        end else if (s1_v < s2_v) begin
            pred = LABEL_SECOND;
        end else begin
            pred = LABEL_NONE;
        end
        ok_next = (item_reg.expected_label != LABEL_NONE) && (pred == item_reg.expected_label);
    end

    always_comb begin
        if (wlen_reg == '0) begin
            len_eff = CW'(1);
        end else if (32'(wlen_reg) > WINDOW_MAX) begin
            len_eff = CW'(WINDOW_MAX);
        end else begin
            len_eff = CW'(wlen_reg);
        end
    end

    assign window_full = (fill_reg >= len_eff);

    always_comb begin
        int unsigned h;
        int unsigned f;
        h = 32'(head_reg);
        f = 32'(fill_reg);
        if (h >= f) begin
            old_idx = AW'(h - f);
        end else begin
            old_idx = AW'(h + WINDOW_MAX - f);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:   if (s_valid) state_next = F_READ;
            F_READ:   state_next = F_REMOVE;
            F_REMOVE: state_next = F_APPEND;
            F_APPEND: if (!q_stat.full) state_next = F_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        s_ready     = 1'b0;
        ram_re      = 1'b0;
        append_fire = 1'b0;
        unique case (state_reg)
            F_IDLE:   s_ready = 1'b1;
            F_READ:   ram_re = 1'b1;
            F_REMOVE: ;
            F_APPEND: append_fire = !q_stat.full;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign ram_we    = append_fire;
    assign ram_wdata = {ok_reg, eff_v, ene_v};
    assign q_push    = append_fire;

    assign count_sum = count_reg + CW'(ok_reg);
    assign eff_sum   = eff_tot_reg + TW'(eff_v);
    assign ene_sum   = ene_tot_reg + TW'(ene_v);
    assign q_data    = {ok_reg, count_sum, eff_sum, ene_sum, len_eff};

    always_comb begin
        wlen_next    = wlen_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        eff_tot_next = eff_tot_reg;
        ene_tot_next = ene_tot_reg;
        if (cfg_valid) begin
            wlen_next    = cfg_data;
            head_next    = '0;
            fill_next    = '0;
            count_next   = '0;
            eff_tot_next = '0;
            ene_tot_next = '0;
        end else if (state_reg == F_REMOVE && window_full) begin
            fill_next    = fill_reg - CW'(1);
            count_next   = count_reg - CW'(rd_flag);
            eff_tot_next = eff_tot_reg - TW'(rd_eff);
            ene_tot_next = ene_tot_reg - TW'(rd_ene);
        end else if (append_fire) begin
            fill_next    = fill_reg + CW'(1);
            count_next   = count_sum;
            eff_tot_next = eff_sum;
            ene_tot_next = ene_sum;
            if (32'(head_reg) == WINDOW_MAX - 1) begin
                head_next = '0;
            end else begin
                head_next = head_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            wlen_reg    <= WLEN_RESET;
            head_reg    <= '0;
            fill_reg    <= '0;
            count_reg   <= '0;
            eff_tot_reg <= '0;
            ene_tot_reg <= '0;
        end else begin
            state_reg   <= state_next;
            wlen_reg    <= wlen_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            eff_tot_reg <= eff_tot_next;
            ene_tot_reg <= ene_tot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == F_READ) begin
            ok_reg <= ok_next;
        end
    end

    wcm_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (old_idx),
        .rdata (ram_rdata)
    );

endmodule

/* hdl/wcm_fifo.sv */
// Short queue of window snapshots between the front and back ends.
// Depends on wcm_pkg for the status struct.
module wcm_fifo
    import wcm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fifo_status_t     stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]    fill_reg, fill_next;

    assign pop_data   = mem[rd_ptr_reg];
    assign stat.full  = (32'(fill_reg) == DEPTH);
    assign stat.empty = (fill_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/wcm_back.sv */
// Back end: runs the three divisions of an item on one shared radix-2 divider
// and holds the result in the output register. Depends on wcm_pkg.
module wcm_back
    import wcm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int CW = $clog2(WINDOW_MAX + 1),
    localparam int TW = VALUE_WIDTH + $clog2(WINDOW_MAX),
    localparam int QW = 1 + 2 * CW + 2 * TW
) (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          q_pop,
    input  logic [QW-1:0] q_data,
    input  fifo_status_t  q_stat,
    output logic          m_valid,
    input  logic          m_ready,
    output out_item_t     m_data
);

    localparam int SW = $clog2(DIV_STEPS + 1);

    back_state_t   state_reg, state_next;
    div_op_t       op_reg, op_next;
    logic [QW-1:0] entry_reg;
    logic [TW-1:0] rem_reg, div_reg;
    logic [31:0]   quo_reg;
    logic [SW-1:0] step_reg;
    logic [31:0]   res_eff_reg, res_ene_reg;
    logic [16:0]   res_ratio_reg;
    logic          m_valid_reg;
    out_item_t     m_data_reg;

    logic          e_ok;
    logic [CW-1:0] e_count, e_len;
    logic [TW-1:0] e_eff, e_ene;
    logic [TW-1:0] divisor, count_ext, shifted;
    logic          div_ge, div_skip, div_start, last_step;
    logic          store_en, advance, out_load;
    logic [31:0]   skip_val, store_val, quo_next;

    assign {e_ok, e_count, e_eff, e_ene, e_len} = entry_reg;

    always_comb begin
        case (op_reg)
            OP_EFFORT: divisor = e_eff;
            OP_ENERGY: divisor = e_ene;
            default:   divisor = TW'(e_len);
        endcase
    end

    assign count_ext = TW'(e_count);
    assign shifted   = {rem_reg[TW-2:0], 1'b0};
    assign div_ge    = (shifted >= div_reg);
    assign quo_next  = {quo_reg[30:0], div_ge};
    assign last_step = (step_reg == SW'(1));

    // A divisor (total or window length) that is not positive gives zero; a count not below it saturates.
    always_comb begin
        div_skip = 1'b1;
        if (divisor[TW-1] || divisor == '0) begin
            skip_val = '0;
        end else if (count_ext >= divisor) begin
            skip_val = (op_reg == OP_RATIO) ? RATIO_SAT : METRIC_SAT;
        end else begin
            skip_val = '0;
            div_skip = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!q_stat.empty) state_next = B_SETUP;
            B_SETUP: begin
                if (!div_skip) begin
                    state_next = B_ITER;
                end else if (op_reg == OP_RATIO) begin
                    state_next = B_OUT;
                end
            end
            B_ITER: begin
                if (last_step) begin
                    state_next = (op_reg == OP_RATIO) ? B_OUT : B_SETUP;
                end
            end
            B_OUT:   if (!m_valid_reg || m_ready) state_next = B_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        store_en  = 1'b0;
        store_val = skip_val;
        out_load  = 1'b0;
        unique case (state_reg)
            B_IDLE:  q_pop = !q_stat.empty;
            B_SETUP: begin
                div_start = !div_skip;
                store_en  = div_skip;
            end
            B_ITER: begin
                store_en  = last_step;
                store_val = quo_next;
            end
            B_OUT:   out_load = !m_valid_reg || m_ready;
        endcase
    end

    assign advance = store_en;

    always_comb begin
        op_next = op_reg;
        if (q_pop) begin
            op_next = OP_EFFORT;
        end else if (advance) begin
            case (op_reg)
                OP_EFFORT: op_next = OP_ENERGY;
                OP_ENERGY: op_next = OP_RATIO;
                default:   op_next = OP_RATIO;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            op_reg      <= OP_EFFORT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            entry_reg <= q_data;
        end
        if (div_start) begin
            rem_reg  <= count_ext;
            div_reg  <= divisor;
            quo_reg  <= '0;
            step_reg <= (op_reg == OP_RATIO) ? SW'(RATIO_STEPS) : SW'(DIV_STEPS);
        end else if (state_reg == B_ITER) begin
            rem_reg  <= div_ge ? (shifted - div_reg) : shifted;
            quo_reg  <= quo_next;
            step_reg <= step_reg - SW'(1);
        end
        if (store_en) begin
            case (op_reg)
                OP_EFFORT: res_eff_reg   <= store_val;
                OP_ENERGY: res_ene_reg   <= store_val;
                default:   res_ratio_reg <= store_val[16:0];
            endcase
        end
        if (out_load) begin
            m_data_reg.item_correct  <= e_ok;
            m_data_reg.effort_metric <= res_eff_reg;
            m_data_reg.energy_metric <= res_ene_reg;
            m_data_reg.correct_ratio <= res_ratio_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
